### rtl/core/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared widths, character codes and the base64url alphabet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int CharWidth   = 8;
    localparam int SextetWidth = 6;
    localparam int AccWidth    = 3 * SextetWidth;
    localparam int GroupWidth  = 4 * SextetWidth;
    localparam int ByteWidth   = 8;

    typedef logic [CharWidth-1:0]   char_t;
    typedef logic [SextetWidth-1:0] sextet_t;
    typedef logic [AccWidth-1:0]    acc_t;
    typedef logic [GroupWidth-1:0]  group_t;
    typedef logic [ByteWidth-1:0]   byte_t;
    typedef logic [1:0]             pos_t;

    localparam pos_t  PosLast     = 2'd3;
    localparam pos_t  ByteIdxLast = 2'd2;

    localparam char_t ChUpperA = 8'h41;
    localparam char_t ChUpperZ = 8'h5A;
    localparam char_t ChLowerA = 8'h61;
    localparam char_t ChLowerZ = 8'h7A;
    localparam char_t ChDigit0 = 8'h30;
    localparam char_t ChDigit9 = 8'h39;
    localparam char_t ChDash   = 8'h2D;
    localparam char_t ChUscore = 8'h5F;

    // '=' and anything outside the alphabet decode to zero
    function automatic sextet_t char_to_sextet(input char_t c);
        char_t d;
        d = '0;
        if (c >= ChUpperA && c <= ChUpperZ) begin
            d = c - ChUpperA;
        end else if (c >= ChLowerA && c <= ChLowerZ) begin
            d = c - ChLowerA + 8'd26;
        end else if (c >= ChDigit0 && c <= ChDigit9) begin
            d = c - ChDigit0 + 8'd52;
        end else if (c == ChDash) begin
            d = 8'd62;
        end else if (c == ChUscore) begin
            d = 8'd63;
        end
        return d[SextetWidth-1:0];
    endfunction

endpackage

### rtl/core/base64url_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_stream_decoder_core
// Decodes a base64url character stream into bytes, three per four characters.
// ----------------------------------------------------------------------------
// Input channel s_axis: one character per item in tdata, tlast on the final
// character of a message. Output channel m_axis: one decoded byte per item,
// tuser high on the third byte of each group, tlast on the third byte of a
// group that closed the message. A message ending on a partial group drops
// that group silently.
// Throughput: one character per cycle unless a held group stalls the input;
// a complete group loads into the output buffer on its fourth character and,
// with a ready receiver, drains one byte per cycle ahead of the next group.
// Latency: the first byte of a group is valid the cycle after the fourth
// character is accepted.
// If the receiver stalls, the output buffer holds its group and the input
// keeps taking characters until the next group completes; the fourth
// character then waits until the last byte of the held group is taken.
// Reset clears the group position, the accumulator and the output buffer.
// ----------------------------------------------------------------------------
module base64url_stream_decoder_core
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [b64d_pkg::CharWidth-1:0] s_axis_tdata,  // [7:0] char_in
    input  logic                         s_axis_tlast,    // msg_end

    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [b64d_pkg::ByteWidth-1:0] m_axis_tdata,  // [7:0] byte_out
    output logic                         m_axis_tuser,    // [0] group_last
    output logic                         m_axis_tlast     // message_last
);

    b64d_pkg::pos_t    pos_reg, pos_next;
    b64d_pkg::acc_t    acc_reg, acc_next;
    b64d_pkg::group_t  group_reg;
    b64d_pkg::pos_t    idx_reg;
    logic              out_valid_reg;
    logic              end_reg;
    b64d_pkg::sextet_t sextet;
    logic              in_accept;
    logic              out_accept;
    logic              load;
    logic              buf_free;

    assign sextet     = b64d_pkg::char_to_sextet(s_axis_tdata);
    assign out_accept = out_valid_reg && m_axis_tready;
    // buffer empties this cycle if its last byte is taken
    assign buf_free   = !out_valid_reg || (out_accept && idx_reg == b64d_pkg::ByteIdxLast);
    assign s_axis_tready = (pos_reg != b64d_pkg::PosLast) || buf_free;
    assign in_accept  = s_axis_tvalid && s_axis_tready;
    assign load       = in_accept && (pos_reg == b64d_pkg::PosLast);

    always_comb
    begin
        pos_next = pos_reg;
        acc_next = acc_reg;
        if (in_accept) begin
            if (pos_reg == b64d_pkg::PosLast || s_axis_tlast) begin
                pos_next = '0;
                acc_next = '0;
            end else begin
                pos_next = pos_reg + 2'd1;
                acc_next = {acc_reg[b64d_pkg::AccWidth-b64d_pkg::SextetWidth-1:0], sextet};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            end_reg       <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            if (load) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= '0;
                end_reg       <= s_axis_tlast;
            end else if (out_accept) begin
                if (idx_reg == b64d_pkg::ByteIdxLast) begin
                    out_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            group_reg <= {acc_reg, sextet};
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    m_axis_tdata = group_reg[23:16];
            2'd1:    m_axis_tdata = group_reg[15:8];
            default: m_axis_tdata = group_reg[7:0];
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = (idx_reg == b64d_pkg::ByteIdxLast);
    assign m_axis_tlast  = (idx_reg == b64d_pkg::ByteIdxLast) && end_reg;

    // a completed group starts draining from its high byte
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (out_valid_reg && idx_reg == 2'd0))
        else $error("group load did not start at high byte");

    // byte index never passes the third byte while draining
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (idx_reg != b64d_pkg::PosLast))
        else $error("byte index out of range");

    // message end always clears the group position
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_axis_tlast) |=> (pos_reg == 2'd0 && acc_reg == '0))
        else $error("message end did not clear group state");

    // message_last only on a group's final byte
    a_last_on_group_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
        else $error("message_last without group_last");

    // a held group is never overwritten before its last byte leaves
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_valid_reg) |-> (out_accept && idx_reg == b64d_pkg::ByteIdxLast))
        else $error("output group overwritten");

endmodule
